// ----- src/sbm_pkg.sv -----
package sbm_pkg;

    localparam int MAX_HEIGHT = 16384;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SRGB_MODE  = 2'd2;

    // one target pixel's four taps: top-left, top-right, bottom-left, bottom-right
    typedef struct packed {
        logic [3:0][31:0] tap;
        logic             last;
    } sbm_item_t;

    // srgb n/510 to linear light, unsigned q2.30
    function automatic logic [63:0] lin_q30(input int unsigned n);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        int          i;
        if (n <= 20) begin
            return ((64'(n) * 64'd10) << 30) / 64'd65892;
        end
        t = ((64'(n) * 64'd100 + 64'd2805) << 30) / 64'd53805;
        t2 = (t * t) >> 30;
        lo = 64'd0;
        hi = Q30_ONE;
        // fifth root by bisection, so t2 * root is t^2.4
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = mid;
            for (i = 0; i < 4; i++) begin
                p = (p * mid) >> 30;
            end
            if (p <= t2) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return (t2 * lo) >> 30;
    endfunction

    function automatic logic [255:0][15:0] build_dec();
        logic [255:0][15:0] d;
        int                 i;
        for (i = 0; i < 256; i++) begin
            d[i] = 16'((lin_q30(2 * i) * 64'd65535 + (Q30_ONE >> 1)) >> 30);
        end
        return d;
    endfunction

    function automatic logic [254:0][17:0] build_thr();
        logic [254:0][17:0] d;
        int                 i;
        for (i = 0; i < 255; i++) begin
            d[i] = 18'((lin_q30(2 * i + 1) * 64'd262140 + Q30_ONE - 64'd1) >> 30);
        end
        return d;
    endfunction

    localparam logic [255:0][15:0] DEC_LUT = build_dec();
    localparam logic [254:0][17:0] ENC_THR = build_thr();

    // two bits of the binary search for the encoded code, msb first
    function automatic logic [7:0] enc_step2(input logic [7:0] code, input logic [17:0] sum,
                                             input int unsigned bit_hi);
        logic [7:0] c;
        logic [7:0] cand;
        c = code;
        cand = c | (8'd1 << bit_hi);
        if (ENC_THR[cand - 8'd1] <= sum) begin
            c = cand;
        end
        cand = c | (8'd1 << (bit_hi - 1));
        if (ENC_THR[cand - 8'd1] <= sum) begin
            c = cand;
        end
        return c;
    endfunction

endpackage

// ----- src/sbm_ram.sv -----
module sbm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sbm_front.sv -----
module sbm_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [14:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_red,
    input  logic [7:0]          s_in_green,
    input  logic [7:0]          s_in_blue,
    input  logic [7:0]          s_in_alpha,
    output logic                push_valid,
    input  logic                push_ready,
    output sbm_pkg::sbm_item_t  push_item,
    output logic                srgb_mode
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [12:0]   width_reg;
    logic [14:0]   height_reg;
    logic          srgb_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [13:0]   row_reg, row_next;
    logic [31:0]   hold_reg;

    logic [WW-1:0] w_eff, tw;
    logic [14:0]   h_eff, th;
    logic          single_row, single_col, col_end, row_end, pair_last_col, pair_last_row;
    logic          fire, emit, hold_load, ram_we, ram_re, restart;
    logic [31:0]   px;
    logic [63:0]   ram_rdata;
    logic [AW-1:0] ram_addr;

    assign px = {s_in_alpha, s_in_blue, s_in_green, s_in_red};

    always_comb begin
        if (width_reg == 13'd0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == 15'd0) begin
            h_eff = 15'd1;
        end else if (32'(height_reg) > 32'(sbm_pkg::MAX_HEIGHT)) begin
            h_eff = 15'(sbm_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        tw = ((w_eff >> 1) == WW'(0)) ? WW'(1) : (w_eff >> 1);
        th = ((h_eff >> 1) == 15'd0) ? 15'd1 : (h_eff >> 1);
    end

    assign single_row    = (h_eff == 15'd1);
    assign single_col    = (w_eff == WW'(1));
    assign col_end       = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign row_end       = (15'(row_reg) + 15'd1) >= h_eff;
    assign pair_last_col = WW'(col_reg >> 1) == (tw - WW'(1));
    assign pair_last_row = 15'(row_reg >> 1) == (th - 15'd1);

    assign s_ready = push_ready;
    assign fire    = s_valid && s_ready;
    assign restart = cfg_wr_en && (cfg_addr == sbm_pkg::REG_SRC_WIDTH ||
                                   cfg_addr == sbm_pkg::REG_SRC_HEIGHT);

    always_comb begin
        emit           = 1'b0;
        hold_load      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        push_item.tap  = {px, hold_reg, px, hold_reg};
        push_item.last = 1'b0;
        if (single_row && single_col) begin
            emit = 1'b0;
        end else if (single_row) begin
            if (!col_reg[0]) begin
                hold_load = 1'b1;
            end else begin
                emit           = 1'b1;
                push_item.tap  = {px, hold_reg, px, hold_reg};
                push_item.last = pair_last_col;
            end
        end else if (single_col) begin
            if (!row_reg[0]) begin
                hold_load = 1'b1;
            end else begin
                emit           = 1'b1;
                push_item.tap  = {px, px, hold_reg, hold_reg};
                push_item.last = pair_last_row;
            end
        end else if (!row_reg[0]) begin
            // even row: pairs of pixels go into the line store
            if (!col_reg[0]) begin
                hold_load = 1'b1;
            end else begin
                ram_we = 1'b1;
            end
        end else begin
            if (!col_reg[0]) begin
                hold_load = 1'b1;
                ram_re    = 1'b1;
            end else begin
                emit           = 1'b1;
                push_item.tap  = {px, hold_reg, ram_rdata[63:32], ram_rdata[31:0]};
                push_item.last = pair_last_col && pair_last_row;
            end
        end
    end

    assign push_valid = fire && emit;
    assign ram_addr   = AW'(col_reg >> 1);

    sbm_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (fire && ram_we),
        .waddr (ram_addr),
        .wdata ({px, hold_reg}),
        .re    (fire && ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (fire) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? 14'd0 : row_reg + 14'd1;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1;
            height_reg <= 15'd1;
            srgb_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            hold_reg   <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (fire && hold_load) begin
                hold_reg <= px;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    sbm_pkg::REG_SRC_WIDTH:  width_reg  <= cfg_wdata[12:0];
                    sbm_pkg::REG_SRC_HEIGHT: height_reg <= cfg_wdata;
                    sbm_pkg::REG_SRGB_MODE:  srgb_reg   <= cfg_wdata[0];
                    default:                 srgb_reg   <= srgb_reg;
                endcase
            end
        end
    end

    assign srgb_mode = srgb_reg;

    // a target pixel only ever completes on an odd column, or in a one-column level
    a_emit_odd_col: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (col_reg[0] || single_col))
        else $error("target pixel emitted on an even column");

endmodule

// ----- src/sbm_queue.sv -----
module sbm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  sbm_pkg::sbm_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output sbm_pkg::sbm_item_t pop_item
);

    sbm_pkg::sbm_item_t entry_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ----- src/sbm_back.sv -----
module sbm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               srgb_mode,
    input  logic               q_valid,
    output logic               pop,
    input  sbm_pkg::sbm_item_t q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_red,
    output logic [7:0]         m_out_green,
    output logic [7:0]         m_out_blue,
    output logic [7:0]         m_out_alpha,
    output logic               m_last_pixel
);

    // stage 0 decodes and sums, stages 1 to 4 each resolve two code bits
    localparam int NST = 5;

    logic [NST-1:0]        v_reg, last_reg;
    logic [3:0][7:0]       code_reg [NST];
    logic [2:0][17:0]      sum_reg  [NST];
    logic [3:0][7:0]       code_next [NST];
    logic [2:0][17:0]      sum0_next;
    logic                  adv;

    assign adv = !v_reg[NST-1] || m_ready;
    assign pop = adv && q_valid;

    always_comb begin
        logic [9:0] avg;
        for (int ch = 0; ch < 4; ch++) begin
            avg = (10'(q_item.tap[0][ch*8 +: 8]) + 10'(q_item.tap[1][ch*8 +: 8]) +
                   10'(q_item.tap[2][ch*8 +: 8]) + 10'(q_item.tap[3][ch*8 +: 8]) +
                   10'd2) >> 2;
            code_next[0][ch] = (srgb_mode && ch < 3) ? 8'd0 : avg[7:0];
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum0_next[ch] = 18'(sbm_pkg::DEC_LUT[q_item.tap[0][ch*8 +: 8]]) +
                            18'(sbm_pkg::DEC_LUT[q_item.tap[1][ch*8 +: 8]]) +
                            18'(sbm_pkg::DEC_LUT[q_item.tap[2][ch*8 +: 8]]) +
                            18'(sbm_pkg::DEC_LUT[q_item.tap[3][ch*8 +: 8]]);
        end
        for (int k = 1; k < NST; k++) begin
            code_next[k] = code_reg[k-1];
            for (int ch = 0; ch < 3; ch++) begin
                if (srgb_mode) begin
                    code_next[k][ch] = sbm_pkg::enc_step2(code_reg[k-1][ch], sum_reg[k-1][ch],
                                                          9 - 2 * k);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], q_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            code_reg[0] <= code_next[0];
            sum_reg[0]  <= sum0_next;
            last_reg[0] <= q_item.last;
            for (int k = 1; k < NST; k++) begin
                code_reg[k] <= code_next[k];
                sum_reg[k]  <= sum_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign m_valid      = v_reg[NST-1];
    assign m_out_red    = code_reg[NST-1][0];
    assign m_out_green  = code_reg[NST-1][1];
    assign m_out_blue   = code_reg[NST-1][2];
    assign m_out_alpha  = code_reg[NST-1][3];
    assign m_last_pixel = last_reg[NST-1];

    // a held result freezes the whole pipe, so nothing may leave the queue
    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("queue popped while output stalled");

endmodule

// ----- src/srgb_box_mip_downsample.sv -----
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_in_red, s_in_green, s_in_blue, s_in_alpha
// m_        out  m_valid/m_ready    m_out_red/green/blue/alpha, m_last_pixel
// cfg_      in   cfg_wr_en          cfg_addr, cfg_wdata
//
// one source pixel per cycle while the queue has room; a target pixel passes from its last
// source beat through the 2-entry queue, the decode/sum stage and four 2-bit encode stages
// the line store is one pair-wide ram, written on even rows and read on odd rows
// reset: synchronous aresetn, counters zero, width and height 1, linear mode
// an output stall freezes the back pipe; the front keeps taking beats until the queue fills
module srgb_box_mip_downsample #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [14:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    input  logic [7:0]  s_in_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic [7:0]  m_out_alpha,
    output logic        m_last_pixel
);

    sbm_pkg::sbm_item_t push_item, pop_item;
    logic               push_valid, push_ready, pop_valid, pop, srgb_mode;

    sbm_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_red   (s_in_red),
        .s_in_green (s_in_green),
        .s_in_blue  (s_in_blue),
        .s_in_alpha (s_in_alpha),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .srgb_mode  (srgb_mode)
    );

    sbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    sbm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .srgb_mode    (srgb_mode),
        .q_valid      (pop_valid),
        .pop          (pop),
        .q_item       (pop_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_last_pixel (m_last_pixel)
    );

endmodule
